FILE: src/spdma_pkg.sv
package spdma_pkg;

  localparam logic [15:0] SPRITE_ADDR_REG = 16'h2003;
  localparam int          PAGE_SHIFT      = 8;

  localparam logic REQ_PAGE_WRITE = 1'b0;
  localparam logic REQ_TICK       = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] page_value;
    logic [7:0] read_data;
  } spdma_in_t;

  typedef struct packed {
    logic        read_enable;
    logic [15:0] read_address;
    logic        sprite_write_enable;
    logic [7:0]  sprite_index;
    logic [7:0]  sprite_data;
    logic        restore_enable;
    logic [7:0]  restore_index;
    logic        busy_res;
  } spdma_out_t;

endpackage

FILE: src/sprite_page_dma_sequencer_top.sv
// Sprite page DMA sequencer. Each input word is either a page register write
// (starts or restarts a 256-byte copy from page*256 into sprite memory) or
// one bus-cycle tick that steps the transfer phase machine; every word
// yields exactly one result word carrying the bus read request, the sprite
// memory write, the sprite address restore and the busy flag. Throughput is
// one word per clock: the block takes a new word every cycle as long as the
// result side keeps up. A word passes through the input register and then
// the result register, with the combinational phase logic between them. A
// stalled result holds in the result register; an empty input register still
// takes one more word, so a back-pressure cycle costs no bubble.
module sprite_page_dma_sequencer_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  spdma_pkg::spdma_in_t  item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output spdma_pkg::spdma_out_t result
);
  import spdma_pkg::*;

  // input register
  logic       in_full;
  spdma_in_t  in_word;

  // result of the phase logic for the word in the input register
  spdma_out_t step_word;
  logic       advance;

  // advance the held word when the result register is free or draining
  assign advance    = in_full && (!result_valid || result_ready);
  assign item_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_ready) begin
      in_full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      in_word <= item;
    end
  end

  spdma_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .word_in  (in_word),
    .word_out (step_word)
  );

  // result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_word;
    end
  end

endmodule

FILE: src/spdma_core.sv
module spdma_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  spdma_pkg::spdma_in_t  word_in,
  output spdma_pkg::spdma_out_t word_out
);
  import spdma_pkg::*;

  logic       transfer_active, transfer_active_next;
  logic       dummy_phase, dummy_phase_next;
  logic       odd_tick, odd_tick_next;
  logic [7:0] source_page, source_page_next;
  logic [7:0] byte_offset, byte_offset_next;
  logic [7:0] held_byte, held_byte_next;
  logic [7:0] saved_addr, saved_addr_next;

  always_comb begin
    transfer_active_next = transfer_active;
    dummy_phase_next     = dummy_phase;
    odd_tick_next        = odd_tick;
    source_page_next     = source_page;
    byte_offset_next     = byte_offset;
    held_byte_next       = held_byte;
    saved_addr_next      = saved_addr;
    word_out             = '0;

    if (word_in.req_type == REQ_PAGE_WRITE) begin
      // restart: keep phase flags and saved address
      transfer_active_next = 1'b1;
      byte_offset_next     = '0;
      source_page_next     = word_in.page_value;
    end else if (transfer_active) begin
      odd_tick_next = !odd_tick;
      if (dummy_phase) begin
        if (odd_tick) begin
          dummy_phase_next      = 1'b0;
          word_out.read_enable  = 1'b1;
          word_out.read_address = SPRITE_ADDR_REG;
          saved_addr_next       = word_in.read_data;
        end
      end else if (!odd_tick) begin
        word_out.read_enable  = 1'b1;
        word_out.read_address = {source_page, byte_offset};
        held_byte_next        = word_in.read_data;
      end else begin
        word_out.sprite_write_enable = 1'b1;
        word_out.sprite_index        = byte_offset;
        word_out.sprite_data         = held_byte;
        byte_offset_next             = byte_offset + 8'd1;
        if (byte_offset == 8'hFF) begin
          // last byte: restore sprite address, drop busy
          transfer_active_next    = 1'b0;
          dummy_phase_next        = 1'b1;
          odd_tick_next           = 1'b0;
          word_out.restore_enable = 1'b1;
          word_out.restore_index  = saved_addr;
        end
      end
    end

    word_out.busy_res = transfer_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      transfer_active <= 1'b0;
      dummy_phase     <= 1'b1;
      odd_tick        <= 1'b0;
      source_page     <= '0;
      byte_offset     <= '0;
      held_byte       <= '0;
      saved_addr      <= '0;
    end else if (step) begin
      transfer_active <= transfer_active_next;
      dummy_phase     <= dummy_phase_next;
      odd_tick        <= odd_tick_next;
      source_page     <= source_page_next;
      byte_offset     <= byte_offset_next;
      held_byte       <= held_byte_next;
      saved_addr      <= saved_addr_next;
    end
  end

endmodule
